// ----- hw/rtl/slef_pkg.sv -----
// ----------------------------------------------------------------------------
// Frame receiver package
// Phase codes, register indexes and frame limits shared by the receiver.
// ----------------------------------------------------------------------------
package slef_pkg;

    localparam int MAX_LEN     = 8;
    localparam int STORE_DEPTH = 8;
    localparam int STORE_IDX_W = $clog2(STORE_DEPTH);
    localparam int BYTE_W      = 8;
    localparam int LEN_W       = 4;
    localparam int PAYLOAD_W   = STORE_DEPTH * BYTE_W;

    typedef enum logic [1:0] {
        PH_HUNT = 2'd0,
        PH_LEN  = 2'd1,
        PH_DATA = 2'd2,
        PH_END  = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        REG_SYNC_EXTERNAL = 2'd0,
        REG_SYNC_INTERNAL = 2'd1,
        REG_END_MARKER    = 2'd2,
        REG_UNUSED        = 2'd3
    } reg_index_t;

    localparam logic [7:0] SYNC_EXTERNAL_RST = 8'hAA;
    localparam logic [7:0] SYNC_INTERNAL_RST = 8'hAB;
    localparam logic [7:0] END_MARKER_RST    = 8'h55;

endpackage

// ----- hw/rtl/sync_length_end_frame_receiver_core.sv -----
// ----------------------------------------------------------------------------
// Length-prefixed frame receiver
// Hunts for a sync byte, takes a length byte, stores the data bytes and
// emits one frame when the closing byte matches the end marker.
//
//  Channel  Direction  Payload
//  s_*      in         tdata[7:0] rx_byte
//  m_*      out        tdata[3:0] frame_length, [67:4] payload; tuser is_external
//  cfg_*    in         cfg_index register, cfg_data value
//
// Bytes are taken one per cycle while s_tready is high; only those move the phase.
// A frame appears on m_* in the cycle after its end byte is transferred.
// Reset clears the phase and output valid; the sync and end registers
// return to their defaults. Only the end byte waits on a stalled output.
// ----------------------------------------------------------------------------
module sync_length_end_frame_receiver_core
    import slef_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // [3:0] frame_length, [67:4] payload, [71:68] zero
    output logic [0:0]  m_tuser,   // [0] is_external
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    phase_t                 phase_reg, phase_next;
    logic                   kind_reg, kind_next;
    logic [LEN_W-1:0]       stored_reg, stored_next;
    logic [LEN_W-1:0]       announced_reg, announced_next;
    logic [BYTE_W-1:0]      store_mem [STORE_DEPTH];
    logic                   store_we;

    logic [BYTE_W-1:0]      sync_ext_reg, sync_int_reg, end_marker_reg;

    logic                   out_valid_reg;
    logic                   out_kind_reg;
    logic [LEN_W-1:0]       out_len_reg;
    logic [PAYLOAD_W-1:0]   out_payload_reg;
    logic [PAYLOAD_W-1:0]   packed_payload;

    logic [BYTE_W-1:0]      rx_byte;
    logic                   in_xfer;
    logic                   ext_hit, int_hit;
    logic                   room_left;
    logic [LEN_W-1:0]       stored_inc;
    logic                   result_fire;

    assign rx_byte    = s_tdata;
    assign s_tready   = (phase_reg != PH_END) || !out_valid_reg || m_tready;
    assign in_xfer    = s_tvalid && s_tready;
    assign cfg_ready  = 1'b1;

    assign ext_hit    = (rx_byte == sync_ext_reg);
    assign int_hit    = (rx_byte == sync_int_reg);
    assign room_left  = (stored_reg < LEN_W'(MAX_LEN));
    assign stored_inc = stored_reg + LEN_W'(1);

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (in_xfer)
        begin
            unique case (phase_reg)
                PH_HUNT:
                begin
                    if (ext_hit || int_hit)
                        phase_next = PH_LEN;
                end
                PH_LEN:
                begin
                    if (rx_byte <= BYTE_W'(MAX_LEN))
                        phase_next = (rx_byte == '0) ? PH_END : PH_DATA;
                    else
                        phase_next = PH_HUNT;
                end
                PH_DATA:
                begin
                    if (!room_left)
                        phase_next = PH_HUNT;
                    else if (stored_inc >= announced_reg)
                        phase_next = PH_END;
                end
                PH_END:
                    phase_next = PH_HUNT;
                default:
                    phase_next = PH_HUNT;
            endcase
        end
    end

    // frame bookkeeping and result
    always_comb
    begin
        kind_next      = kind_reg;
        stored_next    = stored_reg;
        announced_next = announced_reg;
        store_we       = 1'b0;
        result_fire    = 1'b0;
        if (in_xfer)
        begin
            unique case (phase_reg)
                PH_HUNT:
                begin
                    if (ext_hit || int_hit)
                    begin
                        kind_next   = ext_hit;
                        stored_next = '0;
                    end
                end
                PH_LEN:
                begin
                    if (rx_byte <= BYTE_W'(MAX_LEN))
                        announced_next = rx_byte[LEN_W-1:0];
                end
                PH_DATA:
                begin
                    if (room_left)
                    begin
                        store_we    = 1'b1;
                        stored_next = stored_inc;
                    end
                end
                PH_END:
                    result_fire = (rx_byte == end_marker_reg);
                default:
                    result_fire = 1'b0;
            endcase
        end
    end

    // pack stored bytes, zero those beyond the stored count
    always_comb
    begin
        for (int k = 0; k < STORE_DEPTH; k++)
        begin
            if (LEN_W'(k) < stored_reg)
                packed_payload[k*BYTE_W +: BYTE_W] = store_mem[k];
            else
                packed_payload[k*BYTE_W +: BYTE_W] = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (store_we)
            store_mem[stored_reg[STORE_IDX_W-1:0]] <= rx_byte;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HUNT;
            kind_reg      <= 1'b0;
            stored_reg    <= '0;
            announced_reg <= '0;
        end
        else
        begin
            phase_reg     <= phase_next;
            kind_reg      <= kind_next;
            stored_reg    <= stored_next;
            announced_reg <= announced_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_ext_reg   <= SYNC_EXTERNAL_RST;
            sync_int_reg   <= SYNC_INTERNAL_RST;
            end_marker_reg <= END_MARKER_RST;
        end
        else if (cfg_valid)
        begin
            unique case (reg_index_t'(cfg_index))
                REG_SYNC_EXTERNAL: sync_ext_reg   <= cfg_data;
                REG_SYNC_INTERNAL: sync_int_reg   <= cfg_data;
                REG_END_MARKER:    end_marker_reg <= cfg_data;
                REG_UNUSED:        ;
                default:           ;
            endcase
        end
    end

    // output register: load on a good end byte, drop on transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (result_fire)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (result_fire)
        begin
            out_kind_reg    <= kind_reg;
            out_len_reg     <= stored_reg;
            out_payload_reg <= packed_payload;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_payload_reg, out_len_reg};
    assign m_tuser  = out_kind_reg;

endmodule

// ----- tb/tb_sync_length_end_frame_receiver_core.sv -----
// ----------------------------------------------------------------------------
// Frame receiver testbench
// Streams bytes into the receiver, predicts the frames it should emit and
// checks every output transfer field by field. A short directed table covers
// reset defaults, length extremes, dropped frames and equal sync bytes. The
// random part follows over several register settings, with random idling on
// both sides, one long output stall and pauses for register writes.
// ----------------------------------------------------------------------------
module tb_sync_length_end_frame_receiver_core;
    import slef_pkg::*;

    localparam int IDLE_LIMIT    = 2000;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_BYTES   = 210;
    localparam int LONG_STALL    = 400;

    typedef struct packed {
        logic                 is_external;
        logic [LEN_W-1:0]     length;
        logic [PAYLOAD_W-1:0] payload;
    } frame_t;

    typedef struct packed {
        bit          is_cfg;
        reg_index_t  idx;
        logic [7:0]  val;
        bit          typed;
        frame_t      exp;
    } plan_row_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [71:0] m_tdata;
    logic [0:0]  m_tuser;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [7:0]  cfg_data;

    // Predictor state
    logic [7:0]       sync_ext_q;
    logic [7:0]       sync_int_q;
    logic [7:0]       end_q;
    phase_t           rx_phase;
    logic             kind_q;
    logic [LEN_W-1:0] stored_cnt;
    logic [LEN_W-1:0] announced_len;
    logic [7:0]       payload_bytes [STORE_DEPTH];

    frame_t    expected_frames [$];
    plan_row_t plan [$];
    bit        failed;
    bit        sender_burst;
    int        frames_checked;
    int        idle_cycles;

    sync_length_end_frame_receiver_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    task automatic deframe_byte(input logic [7:0] b, output bit got, output frame_t f);
        got = 1'b0;
        f   = '0;
        case (rx_phase)
            PH_HUNT:
            begin
                if (b == sync_ext_q || b == sync_int_q)
                begin
                    // external wins when both registers hold the same byte
                    kind_q     = (b == sync_ext_q);
                    stored_cnt = '0;
                    rx_phase   = PH_LEN;
                end
            end
            PH_LEN:
            begin
                if (b <= MAX_LEN)
                begin
                    announced_len = b[LEN_W-1:0];
                    rx_phase      = (b == 8'd0) ? PH_END : PH_DATA;
                end
                else
                begin
                    rx_phase = PH_HUNT;
                end
            end
            PH_DATA:
            begin
                if (stored_cnt < MAX_LEN)
                begin
                    payload_bytes[stored_cnt[STORE_IDX_W-1:0]] = b;
                    stored_cnt = stored_cnt + 1'b1;
                    if (stored_cnt >= announced_len)
                        rx_phase = PH_END;
                end
                else
                begin
                    rx_phase = PH_HUNT;
                end
            end
            default:
            begin
                if (b == end_q)
                begin
                    got           = 1'b1;
                    f.is_external = kind_q;
                    f.length      = stored_cnt;
                    for (int i = 0; i < STORE_DEPTH; i++)
                        if (i < stored_cnt)
                            f.payload[BYTE_W*i +: BYTE_W] = payload_bytes[i];
                end
                rx_phase = PH_HUNT;
            end
        endcase
    endtask

    function automatic void plan_byte(input logic [7:0] b);
        plan_row_t r;
        r     = '0;
        r.val = b;
        plan.push_back(r);
    endfunction

    function automatic void plan_end(input logic [7:0] b, input logic ext,
                                     input logic [LEN_W-1:0] len,
                                     input logic [PAYLOAD_W-1:0] payload);
        plan_row_t r;
        r                 = '0;
        r.val             = b;
        r.typed           = 1'b1;
        r.exp.is_external = ext;
        r.exp.length      = len;
        r.exp.payload     = payload;
        plan.push_back(r);
    endfunction

    function automatic void plan_cfg(input reg_index_t idx, input logic [7:0] v);
        plan_row_t r;
        r        = '0;
        r.is_cfg = 1'b1;
        r.idx    = idx;
        r.val    = v;
        plan.push_back(r);
    endfunction

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic push_byte(input logic [7:0] b, input bit typed, input frame_t typed_frame);
        int     gap;
        bit     got;
        frame_t f;
        gap = sender_burst ? 0 : $urandom_range(0, 10);
        repeat (gap) @(negedge clk);
        s_tvalid = 1'b1;
        s_tdata  = b;
        do @(posedge clk); while (!s_tready);
        deframe_byte(b, got, f);
        if (typed)
            expected_frames.push_back(typed_frame);
        else if (got)
            expected_frames.push_back(f);
        @(negedge clk);
        s_tvalid = 1'b0;
    endtask

    task automatic write_reg(input reg_index_t idx, input logic [7:0] v);
        // hold until the output side has drained, then let the block settle
        while (expected_frames.size() != 0) @(negedge clk);
        repeat (4) @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = v;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            REG_SYNC_EXTERNAL: sync_ext_q = v;
            REG_SYNC_INTERNAL: sync_int_q = v;
            REG_END_MARKER:    end_q      = v;
            default:           ;
        endcase
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic check_frame();
        frame_t e;
        if (expected_frames.size() == 0)
        begin
            $error("frame transfer with no frame expected: tuser=%0h tdata=%0h",
                   m_tuser, m_tdata);
            failed = 1'b1;
        end
        else
        begin
            e = expected_frames.pop_front();
            if (m_tuser[0] !== e.is_external)
            begin
                $error("is_external: expected %0h, got %0h", e.is_external, m_tuser[0]);
                failed = 1'b1;
            end
            if (m_tdata[3:0] !== e.length)
            begin
                $error("frame_length: expected %0d, got %0d", e.length, m_tdata[3:0]);
                failed = 1'b1;
            end
            if (m_tdata[67:4] !== e.payload)
            begin
                $error("payload: expected %016h, got %016h", e.payload, m_tdata[67:4]);
                failed = 1'b1;
            end
        end
        frames_checked++;
    endtask

    // Output side: random hold-off per frame, bursts with none, one long stall
    initial
    begin
        int  wait_cycles;
        bit  rx_burst;
        bit  stall_done;
        rx_burst   = 1'b0;
        stall_done = 1'b0;
        m_tready   = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!stall_done && frames_checked >= 50)
            begin
                stall_done = 1'b1;
                m_tready   = 1'b0;
                repeat (LONG_STALL) @(negedge clk);
            end
            wait_cycles = rx_burst ? 0 : $urandom_range(0, 10);
            if (wait_cycles > 0)
            begin
                m_tready = 1'b0;
                repeat (wait_cycles) @(negedge clk);
            end
            m_tready = 1'b1;
            do @(posedge clk); while (!m_tvalid);
            check_frame();
            if ($urandom_range(0, 31) == 0)
                rx_burst = !rx_burst;
        end
    end

    initial
    begin
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    initial
    begin
        logic [7:0] ext_v;
        logic [7:0] int_v;
        logic [7:0] end_v;
        logic [7:0] len;
        int         sent;
        int         pick;
        int         cut;
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        cfg_valid      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        failed         = 1'b0;
        sender_burst   = 1'b0;
        frames_checked = 0;
        sync_ext_q     = SYNC_EXTERNAL_RST;
        sync_int_q     = SYNC_INTERNAL_RST;
        end_q          = END_MARKER_RST;
        rx_phase       = PH_HUNT;
        kind_q         = 1'b0;
        stored_cnt     = '0;
        announced_len  = '0;
        for (int i = 0; i < STORE_DEPTH; i++)
            payload_bytes[i] = '0;

        // Reset defaults: empty external frame, full internal frame
        plan_byte(8'hAA);
        plan_byte(8'h00);
        plan_end(8'h55, 1'b1, 4'd0, 64'd0);
        plan_byte(8'hAB);
        plan_byte(8'h08);
        plan_byte(8'hFF);
        plan_byte(8'h00);
        plan_byte(8'h01);
        plan_byte(8'h80);
        plan_byte(8'h7F);
        plan_byte(8'hFE);
        plan_byte(8'h02);
        plan_byte(8'h40);
        plan_end(8'h55, 1'b0, 4'd8, 64'h4002FE7F_800100FF);
        // length above the limit, then a wrong end byte
        plan_byte(8'hAA);
        plan_byte(8'h09);
        plan_byte(8'hAB);
        plan_byte(8'h01);
        plan_byte(8'h3C);
        plan_byte(8'h54);
        // equal sync bytes start an external frame; unused index is ignored
        plan_cfg(REG_SYNC_EXTERNAL, 8'h00);
        plan_cfg(REG_SYNC_INTERNAL, 8'h00);
        plan_cfg(REG_END_MARKER, 8'hFF);
        plan_cfg(REG_UNUSED, 8'h55);
        plan_byte(8'h00);
        plan_byte(8'hFF);
        plan_byte(8'h00);
        plan_byte(8'h01);
        plan_byte(8'hFF);
        plan_end(8'hFF, 1'b1, 4'd1, 64'h0000_0000_0000_00FF);

        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        foreach (plan[i])
        begin
            if (plan[i].is_cfg)
                write_reg(plan[i].idx, plan[i].val);
            else
                push_byte(plan[i].val, plan[i].typed, plan[i].exp);
        end

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            case (ph)
                0:
                begin
                    ext_v = 8'h00;
                    int_v = 8'hFF;
                    end_v = 8'h80;
                end
                1:
                begin
                    ext_v = 8'hFF;
                    int_v = 8'h00;
                    end_v = 8'h00;
                end
                2:
                begin
                    ext_v = 8'($urandom_range(0, 255));
                    int_v = ext_v;
                    end_v = 8'($urandom_range(0, 255));
                end
                default:
                begin
                    ext_v = 8'($urandom_range(0, 255));
                    int_v = 8'($urandom_range(0, 255));
                    end_v = 8'($urandom_range(0, 255));
                end
            endcase
            write_reg(REG_SYNC_EXTERNAL, ext_v);
            write_reg(REG_SYNC_INTERNAL, int_v);
            write_reg(REG_END_MARKER, end_v);
            if (ph % 2 == 1)
                write_reg(REG_UNUSED, 8'($urandom_range(0, 255)));
            sender_burst = (ph % 3 == 1);

            sent = 0;
            while (sent < PHASE_BYTES)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 75)
                begin
                    len = 8'($urandom_range(0, MAX_LEN));
                    push_byte($urandom_range(0, 1) ? ext_v : int_v, 1'b0, '0);
                    push_byte(len, 1'b0, '0);
                    for (int i = 0; i < len; i++)
                        push_byte(8'($urandom_range(0, 255)), 1'b0, '0);
                    // mostly the right end byte, now and then a broken frame
                    push_byte(($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255)) : end_v,
                              1'b0, '0);
                    sent += len + 3;
                end
                else if (pick < 85)
                begin
                    push_byte($urandom_range(0, 1) ? ext_v : int_v, 1'b0, '0);
                    push_byte(($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom_range(9, 255)),
                              1'b0, '0);
                    sent += 2;
                end
                else if (pick < 92)
                begin
                    // truncate the frame; the next bytes land in its data phase
                    len = 8'($urandom_range(1, MAX_LEN));
                    cut = $urandom_range(0, len - 1);
                    push_byte($urandom_range(0, 1) ? ext_v : int_v, 1'b0, '0);
                    push_byte(len, 1'b0, '0);
                    for (int i = 0; i < cut; i++)
                        push_byte(8'($urandom_range(0, 255)), 1'b0, '0);
                    sent += cut + 2;
                end
                else
                begin
                    push_byte(8'($urandom_range(0, 255)), 1'b0, '0);
                    sent++;
                end
            end
        end

        while (expected_frames.size() != 0) @(negedge clk);
        repeat (10) @(negedge clk);
        if (!failed)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
